/* rtl/assert_macros.svh */
// assertion macros for the calibrator rtl
// no dependencies; included by imb_seq, which checks its own sequencing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IMB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/imb_pkg.sv */
// shared types and constants of the imu median bias calibrator
// no dependencies; imported by every module of the block
package imb_pkg;

   localparam int SAMPLES_DEF      = 128;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int GRAV_W           = 15;
   localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd10035;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SHIFT,
      ST_MEDREQ,
      ST_MEDWAIT,
      ST_FINISH
   } imb_state_type;

   // sequencer to lane controls
   typedef struct packed {
      logic load;         // capture new value, clear done
      logic shift;        // one insertion step
      logic at_bottom;    // walking index is zero
      logic bias_load;    // median read data valid
      logic result_load;  // result register takes the corrected values
   } imb_ctrl_type;

endpackage

/* rtl/imu_median_bias_calibrator_unit.sv */
// imu median bias calibrator: top level, input/result registers, saturation
// depends on imb_pkg, imb_seq and imb_lane
//
// Takes one imu sample per transfer (x/y/z acceleration and yaw rate) and
// returns one result per transfer: each channel minus its bias, saturated to
// the signed sample width, plus a calibrating flag in rsp_tuser. For the first
// SAMPLES transfers after reset each channel value (z with gravity_offset
// removed) is inserted in ascending order into that channel's sorted store and
// the bias becomes the upper median, entry (count)/2 of the new count; the
// result already uses the updated bias. After that the stores and biases
// freeze. The four channels are four lanes driven in lockstep by one
// sequencer; each lane has a single-port-write, single-port-read memory with
// registered read data and one compare step. An insertion walks down from the
// top of the store one entry per cycle until every lane has settled; after
// calibration the stores are skipped and the sequencer goes straight from idle
// to its last step, where the result is registered. The next sample can be
// accepted as soon as the result sits in the output register, even if it has
// not been taken yet. A result still waiting in the output register holds the
// sequencer in its last step until it is taken. gravity_offset is written
// through csr_wr_en/csr_wr_data; the user must do so only while idle, which
// the block itself does not enforce. It resets to 10035.
module imu_median_bias_calibrator_unit #(
   parameter int SAMPLES      = imb_pkg::SAMPLES_DEF,
   parameter int SAMPLE_WIDTH = imb_pkg::SAMPLE_WIDTH_DEF,
   parameter int INB          = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [imb_pkg::GRAV_W-1:0] csr_wr_data,  // gravity_offset
   // sample stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [INB-1:0]            req_tdata,   // accel_x, accel_y, accel_z, yaw_rate
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [INB-1:0]            rsp_tdata,   // corr_accel_x, corr_accel_y,
                                                  // corr_accel_z, corr_yaw_rate
   output logic                      rsp_tuser    // calibrating
);
   import imb_pkg::*;

   localparam int W   = SAMPLE_WIDTH;
   // z store holds the raw value less the gravity offset
   localparam int ZW  = ((W > GRAV_W + 1) ? W : GRAV_W + 1) + 1;
   localparam int DFW = ZW + 1;
   localparam int AW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int CW  = $clog2(SAMPLES + 1);
   localparam int NCH = 4;
   localparam int ZCH = 2;

   logic [GRAV_W-1:0]     grav_ff, grav_in;
   logic signed [W-1:0]   raw_ff [NCH];
   logic signed [W-1:0]   req_raw [NCH];
   logic signed [ZW-1:0]  lane_din [NCH];
   logic signed [ZW-1:0]  lane_bias [NCH];
   logic [NCH-1:0]        lane_settled;
   logic signed [W-1:0]   corr [NCH];
   logic [W-1:0]          rsp_data_ff [NCH];
   logic                  rsp_cal_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   imb_ctrl_type          ctrl;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  start, idle, out_free, calibrating;

   assign start      = req_tvalid && req_tready;
   assign req_tready = idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // gravity offset register
   always_comb begin
      grav_in = grav_ff;
      if (csr_wr_en) begin
         grav_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GRAVITY_RESET;
      end else begin
         grav_ff <= grav_in;
      end
   end

   // unpack the sample and form the values that enter the stores
   for (genvar ch = 0; ch < NCH; ch++) begin : g_unpack
      assign req_raw[ch] = req_tdata[ch*W +: W];
      if (ch == ZCH) begin : g_z
         assign lane_din[ch] = ZW'(req_raw[ch]) - ZW'({1'b0, grav_ff});
      end else begin : g_xy
         assign lane_din[ch] = ZW'(req_raw[ch]);
      end
   end

   // raw sample held for the correction at the end
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         raw_ff <= req_raw;
      end
   end

   imb_seq #(
      .SAMPLES (SAMPLES),
      .AW      (AW),
      .CW      (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .all_settled (&lane_settled),
      .out_free    (out_free),
      .idle        (idle),
      .calibrating (calibrating),
      .ctrl        (ctrl),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr)
   );

   // one lane per channel, z lane is wider
   for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
      localparam int LW = (ch == ZCH) ? ZW : W;
      logic signed [LW-1:0] lane_b;
      imb_lane #(
         .DW    (LW),
         .DEPTH (SAMPLES),
         .AW    (AW)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .wr_addr (wr_addr),
         .rd_addr (rd_addr),
         .din     (lane_din[ch][LW-1:0]),
         .settled (lane_settled[ch]),
         .bias    (lane_b)
      );
      assign lane_bias[ch] = ZW'(lane_b);
   end

   // raw minus bias, saturated to the sample range
   for (genvar ch = 0; ch < NCH; ch++) begin : g_corr
      logic signed [DFW-1:0] diff;
      logic                  in_range;
      assign diff     = DFW'(raw_ff[ch]) - DFW'(lane_bias[ch]);
      assign in_range = (&diff[DFW-1:W-1]) || !(|diff[DFW-1:W-1]);
      always_comb begin
         if (in_range) begin
            corr[ch] = diff[W-1:0];
         end else if (diff[DFW-1]) begin
            corr[ch] = {1'b1, {(W-1){1'b0}}};
         end else begin
            corr[ch] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   // result register: holds one finished transfer while the next sample works
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.result_load) begin
         for (int ch = 0; ch < NCH; ch++) begin
            rsp_data_ff[ch] <= corr[ch];
         end
         rsp_cal_ff <= calibrating;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int ch = 0; ch < NCH; ch++) begin
         rsp_tdata[ch*W +: W] = rsp_data_ff[ch];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cal_ff;

endmodule

/* rtl/imb_lane.sv */
// one channel: sorted store memory, insertion compare step, bias register
// depends on imb_pkg
module imb_lane #(
   parameter int DW    = imb_pkg::SAMPLE_WIDTH_DEF,
   parameter int DEPTH = imb_pkg::SAMPLES_DEF,
   parameter int AW    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  imb_pkg::imb_ctrl_type ctrl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [AW-1:0]         rd_addr,
   input  logic signed [DW-1:0]  din,
   output logic                  settled,
   output logic signed [DW-1:0]  bias
);
   import imb_pkg::*;

   logic signed [DW-1:0] mem [DEPTH];
   logic signed [DW-1:0] rd_data_ff;
   logic signed [DW-1:0] val_ff;
   logic signed [DW-1:0] bias_ff, bias_in;
   logic                 done_ff, done_in;
   logic                 stop;
   logic                 wr_en;
   logic signed [DW-1:0] wr_data;

   // stop at the bottom or once the entry below is not greater
   assign stop    = ctrl.at_bottom || !(rd_data_ff > val_ff);
   assign settled = done_ff || stop;
   assign wr_en   = ctrl.shift && !done_ff;
   assign wr_data = stop ? val_ff : rd_data_ff;
   assign bias    = bias_ff;

   always_comb begin
      done_in = done_ff;
      if (ctrl.load) begin
         done_in = 1'b0;
      end else if (ctrl.shift && stop) begin
         done_in = 1'b1;
      end
   end

   always_comb begin
      bias_in = bias_ff;
      if (ctrl.bias_load) begin
         bias_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         bias_ff <= '0;
      end else begin
         done_ff <= done_in;
         bias_ff <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         val_ff <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

/* rtl/imb_seq.sv */
// sequencer: sample count, walking insertion index, memory addresses
// depends on imb_pkg and assert_macros.svh
`include "assert_macros.svh"
module imb_seq #(
   parameter int SAMPLES = imb_pkg::SAMPLES_DEF,
   parameter int AW      = 7,
   parameter int CW      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  all_settled,
   input  logic                  out_free,
   output logic                  idle,
   output logic                  calibrating,
   output imb_pkg::imb_ctrl_type ctrl,
   output logic [AW-1:0]         wr_addr,
   output logic [AW-1:0]         rd_addr
);
   import imb_pkg::*;

   imb_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] j_ff, j_in;
   logic          cal_ff, cal_in;
   logic          cal_now;
   logic [CW:0]   cnt_inc;
   logic [AW-1:0] med_addr;

   assign cal_now  = count_ff < CW'(SAMPLES);
   assign cnt_inc  = {1'b0, count_ff} + 1'b1;
   assign med_addr = cnt_inc[AW:1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = cal_now ? ST_PRIME : ST_FINISH;
            end
         end
         ST_PRIME: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (all_settled) begin
               state_in = ST_MEDREQ;
            end
         end
         ST_MEDREQ: begin
            state_in = ST_MEDWAIT;
         end
         ST_MEDWAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl             = '0;
      ctrl.at_bottom   = (j_ff == '0);
      rd_addr          = j_ff - 1'b1;
      idle             = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle      = 1'b1;
            ctrl.load = start;
         end
         ST_PRIME: begin
            rd_addr = j_ff - 1'b1;
         end
         ST_SHIFT: begin
            ctrl.shift = 1'b1;
            rd_addr    = j_ff - AW'(2);
         end
         ST_MEDREQ: begin
            rd_addr = med_addr;
         end
         ST_MEDWAIT: begin
            ctrl.bias_load = 1'b1;
         end
         ST_FINISH: begin
            ctrl.result_load = out_free;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   assign wr_addr     = j_ff;
   assign calibrating = cal_ff;

   always_comb begin
      count_in = count_ff;
      j_in     = j_ff;
      cal_in   = cal_ff;
      if (state_ff == ST_IDLE && start) begin
         cal_in = cal_now;
         j_in   = count_ff[AW-1:0];
      end else if (state_ff == ST_SHIFT) begin
         j_in = j_ff - 1'b1;
      end else if (state_ff == ST_MEDWAIT) begin
         count_in = cnt_inc[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         j_ff     <= '0;
         cal_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         j_ff     <= j_in;
         cal_ff   <= cal_in;
      end
   end

   `IMB_ASSERT_NXT(a_bottom_ends_shift, clock, reset, state_ff == ST_SHIFT && j_ff == '0, state_ff == ST_MEDREQ, "insertion walked past entry zero")
   `IMB_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CW'(SAMPLES), "sample count above calibration length")
   `IMB_ASSERT_NXT(a_count_step, clock, reset, state_ff == ST_MEDWAIT, count_ff == $past(count_ff) + 1'b1, "sample count did not advance after median read")
   `IMB_ASSERT_NXT(a_frozen_skip, clock, reset, state_ff == ST_IDLE && start && count_ff == CW'(SAMPLES), state_ff == ST_FINISH && count_ff == CW'(SAMPLES), "frozen calibration touched the stores")

endmodule
